// ----- hw/rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared operation codes, status codes and widths of the rational unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned OperandBitsDefault = 32;
  localparam int unsigned WideBits = 64;

  typedef enum logic [2:0] {
    FUNC_ADD     = 3'd0,
    FUNC_SUB     = 3'd1,
    FUNC_MUL     = 3'd2,
    FUNC_DIV     = 3'd3,
    FUNC_LESS    = 3'd4,
    FUNC_GREATER = 3'd5,
    FUNC_EQUAL   = 3'd6,
    FUNC_REDUCE  = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DIV_ZERO = 2'd1,
    STAT_ZERO_DEN = 2'd2,
    STAT_RSVD     = 2'd3
  } status_e;

  // Start and completion of an iterative unit.
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

// ----- hw/rtl/rau_if.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit channels
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] a_num;
  logic [30:0]        a_den;
  logic signed [31:0] b_num;
  logic [30:0]        b_den;

  modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] res_num;
  logic [62:0]        res_den;
  logic               cmp_flag;
  logic [1:0]         status;

  modport source (output valid, res_num, res_den, cmp_flag, status, input ready);
  modport sink   (input valid, res_num, res_den, cmp_flag, status, output ready);
endinterface

// ----- hw/rtl/rau_mul.sv -----
// ----------------------------------------------------------------------------
// Rational unit multiplier
// Registered signed multiplier shared by all cross products.
// ----------------------------------------------------------------------------
module rau_mul
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = OperandBitsDefault
) (
  input  logic                         clk_i,
  input  logic signed [OPERAND_BITS:0] x_i,
  input  logic signed [OPERAND_BITS:0] y_i,
  output logic signed [WideBits-1:0]   p_o
);

  logic signed [2*OPERAND_BITS+1:0] prod;
  logic signed [WideBits-1:0]       p_q;

  assign prod = x_i * y_i;

  always_ff @(posedge clk_i) begin
    p_q <= WideBits'(prod);
  end

  assign p_o = p_q;

endmodule

// ----- hw/rtl/rau_gcd.sv -----
// ----------------------------------------------------------------------------
// Rational unit gcd engine
// Binary gcd of two nonzero 64-bit values, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
module rau_gcd
  import rau_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WideBits-1:0] a_i,
  input  logic [WideBits-1:0] b_i,
  output logic                done_o,
  output logic [WideBits-1:0] g_o
);

  logic                busy_q;
  logic [WideBits-1:0] a_q, b_q;
  logic [5:0]          sh_q;

  assign done_o = busy_q && a_q[0] && (b_q == '0);
  assign g_o    = a_q << sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      sh_q <= '0;
    end else if (busy_q) begin
      // Common factors of two first, then strip a and b, then subtract.
      if (!a_q[0] && !b_q[0]) begin
        a_q  <= a_q >> 1;
        b_q  <= b_q >> 1;
        sh_q <= sh_q + 6'd1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (b_q == '0) begin
        a_q <= a_q;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q > b_q) begin
        a_q <= b_q;
        b_q <= a_q - b_q;
      end else begin
        b_q <= b_q - a_q;
      end
    end
  end

endmodule

// ----- hw/rtl/rau_div.sv -----
// ----------------------------------------------------------------------------
// Rational unit divider
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div
  import rau_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WideBits-1:0] dividend_i,
  input  logic [WideBits-1:0] divisor_i,
  output logic                done_o,
  output logic [WideBits-1:0] quot_o
);

  localparam int unsigned CntBits = $clog2(WideBits) + 1;

  logic                busy_q;
  logic [CntBits-1:0]  cnt_q;
  logic [WideBits-1:0] rem_q, quo_q, dvs_q;
  logic [WideBits:0]   trial;
  logic                fits;

  assign trial  = {rem_q, quo_q[WideBits-1]};
  assign fits   = trial >= {1'b0, dvs_q};
  assign done_o = busy_q && (cnt_q == CntBits'(WideBits));
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q && !done_o) begin
      rem_q <= fits ? WideBits'(trial - {1'b0, dvs_q}) : trial[WideBits-1:0];
      quo_q <= {quo_q[WideBits-2:0], fits};
    end
  end

endmodule

// ----- hw/rtl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add, subtract, multiply, divide, compare and reduce with gcd.
// ----------------------------------------------------------------------------
// The unit takes one item at a time: in_i.ready is high only while the
// sequencer is idle. An item first runs three products through one shared
// registered multiplier, then the result is reduced: a binary gcd runs on
// the 64-bit magnitudes, and the numerator and denominator are each divided
// by the gcd in turn in a shared restoring divider. Compares and zero
// results finish after the products without reduction; operand errors
// skip the products. A finished result sits in an output register, so
// the next item is taken as soon as that register is free or being
// drained.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = OperandBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);

  localparam int unsigned NumShift = 32 - OPERAND_BITS;
  localparam logic [30:0] DenMask  = 31'((64'd1 << (OPERAND_BITS - 1)) - 64'd1);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_M1   = 11'b00000000010,
    S_M2   = 11'b00000000100,
    S_M3   = 11'b00000001000,
    S_M4   = 11'b00000010000,
    S_SUM  = 11'b00000100000,
    S_SGN  = 11'b00001000000,
    S_GCD  = 11'b00010000000,
    S_DV1  = 11'b00100000000,
    S_DV2  = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Captured operands, already cut to the operand width.
  func_e                        func_q;
  logic signed [OPERAND_BITS:0] an_q, bn_q, ad_q, bd_q;

  logic signed [WideBits-1:0] p1_q, p2_q, p3_q, n_q;
  logic [WideBits-1:0]        mag_q, d_q, g_q;
  logic                       neg_q, flag_q;
  status_e                    status_q;

  logic                       out_valid_q;
  logic signed [63:0]         res_num_q;
  logic [62:0]                res_den_q;
  logic                       res_flag_q;
  status_e                    res_status_q;

  // Input extraction.
  logic signed [31:0]           a_num_x, b_num_x;
  logic [30:0]                  a_den_x, b_den_x;
  logic                         accept;
  status_e                      in_status;

  assign a_num_x = $signed(in_i.a_num << NumShift) >>> NumShift;
  assign b_num_x = $signed(in_i.b_num << NumShift) >>> NumShift;
  assign a_den_x = in_i.a_den & DenMask;
  assign b_den_x = in_i.b_den & DenMask;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    if ((a_den_x == '0) || ((func_e'(in_i.func) != FUNC_REDUCE) && (b_den_x == '0))) begin
      in_status = STAT_ZERO_DEN;
    end else if ((func_e'(in_i.func) == FUNC_DIV) && (b_num_x == '0)) begin
      in_status = STAT_DIV_ZERO;
    end else begin
      in_status = STAT_OK;
    end
  end

  // Shared multiplier: operand selection per product step.
  logic signed [OPERAND_BITS:0] mx, my, one_op;
  logic signed [WideBits-1:0]   mul_p;

  assign one_op = (OPERAND_BITS + 1)'(1);

  always_comb begin
    mx = an_q;
    my = bd_q;
    case (state_q)
      S_M1: begin
        mx = an_q;
        if (func_q == FUNC_MUL) begin
          my = bn_q;
        end else if (func_q == FUNC_REDUCE) begin
          my = one_op;
        end else begin
          my = bd_q;
        end
      end
      S_M2: begin
        mx = bn_q;
        my = ad_q;
      end
      S_M3: begin
        mx = ad_q;
        if (func_q == FUNC_DIV) begin
          my = bn_q;
        end else if (func_q == FUNC_REDUCE) begin
          my = one_op;
        end else begin
          my = bd_q;
        end
      end
      default: begin
        mx = an_q;
        my = bd_q;
      end
    endcase
  end

  rau_mul #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .x_i   (mx),
    .y_i   (my),
    .p_o   (mul_p)
  );

  // gcd engine and shared divider.
  unit_ctl_t           gcd_ctl, div_ctl;
  logic [WideBits-1:0] n_abs, gcd_g, div_dividend, div_divisor, div_quot;

  assign n_abs         = n_q[WideBits-1] ? WideBits'(-n_q) : WideBits'(n_q);
  assign gcd_ctl.start = (state_q == S_SGN) && !func_q[2] && (n_q != '0)
                      || (state_q == S_SGN) && (func_q == FUNC_REDUCE) && (n_q != '0);
  assign div_ctl.start = ((state_q == S_GCD) && gcd_ctl.done)
                      || ((state_q == S_DV1) && div_ctl.done);
  assign div_dividend  = (state_q == S_GCD) ? mag_q : d_q;
  assign div_divisor   = (state_q == S_GCD) ? gcd_g : g_q;

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_ctl.start),
    .a_i     (n_abs),
    .b_i     (d_q),
    .done_o  (gcd_ctl.done),
    .g_o     (gcd_g)
  );

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_ctl.start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_ctl.done),
    .quot_o     (div_quot)
  );

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = (in_status == STAT_OK) ? S_M1 : S_FIN;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_M4;
      S_M4:   state_d = S_SUM;
      S_SUM:  state_d = S_SGN;
      S_SGN:  state_d = gcd_ctl.start ? S_GCD : S_FIN;
      S_GCD:  if (gcd_ctl.done) state_d = S_DV1;
      S_DV1:  if (div_ctl.done) state_d = S_DV2;
      S_DV2:  if (div_ctl.done) state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_q   <= func_e'(in_i.func);
          an_q     <= (OPERAND_BITS + 1)'(a_num_x);
          bn_q     <= (OPERAND_BITS + 1)'(b_num_x);
          ad_q     <= (OPERAND_BITS + 1)'($signed({1'b0, a_den_x}));
          bd_q     <= (OPERAND_BITS + 1)'($signed({1'b0, b_den_x}));
          status_q <= in_status;
          mag_q    <= '0;
          neg_q    <= 1'b0;
          d_q      <= WideBits'(1);
          flag_q   <= 1'b0;
        end
      end
      S_M2: p1_q <= mul_p;
      S_M3: p2_q <= mul_p;
      S_M4: p3_q <= mul_p;
      S_SUM: begin
        case (func_q)
          FUNC_ADD: n_q <= p1_q + p2_q;
          FUNC_SUB: n_q <= p1_q - p2_q;
          FUNC_DIV: n_q <= p3_q[WideBits-1] ? -p1_q : p1_q;
          default:  n_q <= p1_q;
        endcase
        d_q    <= p3_q[WideBits-1] ? WideBits'(-p3_q) : WideBits'(p3_q);
        flag_q <= ((func_q == FUNC_LESS) && (p1_q < p2_q))
               || ((func_q == FUNC_GREATER) && (p1_q > p2_q))
               || ((func_q == FUNC_EQUAL) && (p1_q == p2_q));
      end
      S_SGN: begin
        if (gcd_ctl.start) begin
          neg_q <= n_q[WideBits-1];
          mag_q <= n_abs;
        end else begin
          // Compares and zero results leave 0/1.
          neg_q <= 1'b0;
          mag_q <= '0;
          d_q   <= WideBits'(1);
        end
      end
      S_GCD: if (gcd_ctl.done) g_q <= gcd_g;
      S_DV1: if (div_ctl.done) mag_q <= div_quot;
      S_DV2: if (div_ctl.done) d_q <= div_quot;
      S_FIN: begin
        if (out_free) begin
          res_num_q    <= neg_q ? -$signed(mag_q) : $signed(mag_q);
          res_den_q    <= d_q[62:0];
          res_flag_q   <= flag_q;
          res_status_q <= status_q;
        end
      end
      default: begin
        n_q <= n_q;
      end
    endcase
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.res_num  = res_num_q;
  assign out_o.res_den  = res_den_q;
  assign out_o.cmp_flag = res_flag_q;
  assign out_o.status   = res_status_q;

`ifndef SYNTHESIS
  // A delivered denominator is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.res_den != '0))
    else $error("zero denominator delivered");

  // An error result carries the neutral fraction and no flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != STAT_OK))
      |-> ((out_o.res_num == '0) && (out_o.res_den == 63'd1) && !out_o.cmp_flag))
    else $error("error result not cleared");

  // An accepted item leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted item dropped");

  // The two iterative units never run a start into each other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(gcd_ctl.start && div_ctl.start))
    else $error("gcd and divider started together");
`endif

endmodule
